@@ hw/rtl/atan2_pkg.sv @@
// shared constants, types and coefficient table for the atan2 core
// no dependencies; imported by atan2_div, atan2_poly and the top level
`timescale 1ns / 1ps
`default_nettype none

package atan2_pkg;

	localparam int IN_WIDTH_DEF  = 16;
	localparam int FRAC_BITS_DEF = 13;

	// unsigned ratio min/max in Q1.15
	localparam int RATIO_BITS = 15;
	localparam int T_W        = RATIO_BITS + 1;
	localparam int T2_W       = 2 * RATIO_BITS + 1;
	localparam int COEF_W     = 30;
	localparam int HORNER_N   = 4;

	localparam logic [COEF_W-1:0] COEF1 = 30'd1073597943;
	localparam logic [COEF_W-1:0] COEF3 = 30'd354656388;
	localparam logic [COEF_W-1:0] COEF5 = 30'd193424926;
	localparam logic [COEF_W-1:0] COEF7 = 30'd91410863;
	localparam logic [COEF_W-1:0] COEF9 = 30'd22371518;

	localparam logic [63:0] PI_Q32      = 64'd13493037705;
	localparam logic [63:0] HALF_PI_Q32 = 64'd6746518852;

	typedef struct packed {
		logic sx;   // x negative
		logic sy;   // y negative
		logic xz;   // x zero
		logic yz;   // y zero
		logic swap; // |y| >= |x|
	} atan2_side_t;

	// coefficient subtracted at horner step idx
	function automatic logic [COEF_W-1:0] horner_coef(input logic [1:0] idx);
		logic [COEF_W-1:0] c;
		case (idx)
			2'd0: c = COEF7;
			2'd1: c = COEF5;
			2'd2: c = COEF3;
			2'd3: c = COEF1;
			default: c = COEF1;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/atan2_div.sv @@
// pipelined restoring divider: ratio = floor(min * 2^15 / max), one quotient bit per stage
// depends on atan2_pkg
`timescale 1ns / 1ps
`default_nettype none

module atan2_div #(
	parameter int IN_WIDTH = atan2_pkg::IN_WIDTH_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              en,
	input  wire                              in_vld,
	input  wire  [IN_WIDTH-1:0]              min_mag,
	input  wire  [IN_WIDTH-1:0]              max_mag,
	input  atan2_pkg::atan2_side_t           in_side,
	output logic                             out_vld,
	output logic [atan2_pkg::T_W-1:0]        ratio,
	output atan2_pkg::atan2_side_t           out_side
);
	import atan2_pkg::*;

	logic [IN_WIDTH-1:0] rem_s  [0:RATIO_BITS];
	logic [IN_WIDTH-1:0] max_s  [0:RATIO_BITS];
	logic [T_W-1:0]      quo_s  [0:RATIO_BITS];
	atan2_side_t         side_s [0:RATIO_BITS];
	logic                vld_s  [0:RATIO_BITS];

	logic first_ge;
	assign first_ge = (min_mag >= max_mag);

	// top quotient bit: min never exceeds max, so it is set only on equality
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= first_ge ? (min_mag - max_mag) : min_mag;
			max_s[0]  <= max_mag;
			quo_s[0]  <= {{(T_W-1){1'b0}}, first_ge};
			side_s[0] <= in_side;
		end
	end

	for (genvar k = 1; k <= RATIO_BITS; k++) begin : g_step
		logic [IN_WIDTH:0] shl;
		logic [IN_WIDTH:0] diff;
		logic              ge;

		assign shl  = {rem_s[k-1], 1'b0};
		assign ge   = (shl >= {1'b0, max_s[k-1]});
		assign diff = shl - {1'b0, max_s[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[IN_WIDTH-1:0] : shl[IN_WIDTH-1:0];
				max_s[k]  <= max_s[k-1];
				quo_s[k]  <= {quo_s[k-1][T_W-2:0], ge};
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_vld  = vld_s[RATIO_BITS];
	assign ratio    = quo_s[RATIO_BITS];
	assign out_side = side_s[RATIO_BITS];

endmodule

`default_nettype wire

@@ hw/rtl/atan2_poly.sv @@
// pipelined odd degree-9 polynomial for atan of a Q1.15 ratio, horner form
// depends on atan2_pkg
`timescale 1ns / 1ps
`default_nettype none

module atan2_poly #(
	parameter int FRAC_BITS = atan2_pkg::FRAC_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          en,
	input  wire                          in_vld,
	input  wire  [atan2_pkg::T_W-1:0]    ratio,
	input  atan2_pkg::atan2_side_t       in_side,
	output logic                         out_vld,
	output logic [FRAC_BITS:0]           mag,
	output atan2_pkg::atan2_side_t       out_side
);
	import atan2_pkg::*;

	localparam int PROD_W = COEF_W + T2_W;
	localparam int FIN_W  = COEF_W + T_W;
	localparam int SH     = 3 * RATIO_BITS - FRAC_BITS;

	// boundaries between horner steps
	logic [T_W-1:0]    t_b    [0:HORNER_N];
	logic [T2_W-1:0]   t2_b   [0:HORNER_N];
	logic [COEF_W-1:0] acc_b  [0:HORNER_N];
	atan2_side_t       side_b [0:HORNER_N];
	logic              vld_b  [0:HORNER_N];

	logic [2*T_W-1:0] sq;
	assign sq = ratio * ratio;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_b[0] <= 1'b0;
		end else if (en) begin
			vld_b[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_b[0]    <= ratio;
			t2_b[0]   <= sq[T2_W-1:0];
			acc_b[0]  <= COEF9;
			side_b[0] <= in_side;
		end
	end

	for (genvar j = 0; j < HORNER_N; j++) begin : g_horner
		logic [PROD_W-1:0] prod_m;
		logic [T_W-1:0]    t_m;
		logic [T2_W-1:0]   t2_m;
		atan2_side_t       side_m;
		logic              vld_m;
		logic [T2_W-1:0]   sub;

		assign sub = {1'b0, horner_coef(2'(j))} - prod_m[PROD_W-1:2*RATIO_BITS];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_m      <= 1'b0;
				vld_b[j+1] <= 1'b0;
			end else if (en) begin
				vld_m      <= vld_b[j];
				vld_b[j+1] <= vld_m;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				prod_m      <= acc_b[j] * t2_b[j];
				t_m         <= t_b[j];
				t2_m        <= t2_b[j];
				side_m      <= side_b[j];
				acc_b[j+1]  <= sub[COEF_W-1:0];
				t_b[j+1]    <= t_m;
				t2_b[j+1]   <= t2_m;
				side_b[j+1] <= side_m;
			end
		end
	end

	logic [FIN_W-1:0]  fin_s1;
	atan2_side_t       side_s1;
	logic              vld_s1;
	logic [FIN_W:0]    rnd;

	assign rnd = {1'b0, fin_s1} + (FIN_W+1)'(64'd1 << (SH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			out_vld <= 1'b0;
		end else if (en) begin
			vld_s1  <= vld_b[HORNER_N];
			out_vld <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fin_s1   <= t_b[HORNER_N] * acc_b[HORNER_N];
			side_s1  <= side_b[HORNER_N];
			mag      <= rnd[SH +: FRAC_BITS + 1];
			out_side <= side_s1;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/two_argument_arctangent_core.sv @@
// four-quadrant arctangent core: sign/magnitude split, divider, polynomial, quadrant fold
// depends on atan2_pkg, atan2_div and atan2_poly
`timescale 1ns / 1ps
`default_nettype none

// usage
//   input channel: y_coord, x_coord with coord_valid / coord_stall
//   output channel: angle (signed, FRAC_BITS fraction bits, -pi..pi)
//   with angle_valid / angle_stall
//   a transaction moves when valid is high and stall is low
// throughput: one transaction per cycle while the receiver does not stall
// pipeline from input transaction to angle_valid:
//   16 divider stages, one quotient bit each, 11 polynomial stages with
//   a register after every multiply, and one fold stage
// the whole pipeline advances as one; when angle_valid is high and the
// receiver stalls, every stage holds and coord_stall is raised, so
// nothing is lost or repeated; bubbles travel as cleared valid bits
// reset clears all valid bits; data registers are not reset
// x zero gives +pi/2, 0 or -pi/2 by the sign of y

module two_argument_arctangent_core #(
	parameter int IN_WIDTH  = atan2_pkg::IN_WIDTH_DEF,
	parameter int FRAC_BITS = atan2_pkg::FRAC_BITS_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         coord_valid,
	output logic                        coord_stall,
	input  wire  signed [IN_WIDTH-1:0]  y_coord,
	input  wire  signed [IN_WIDTH-1:0]  x_coord,
	output logic                        angle_valid,
	input  wire                         angle_stall,
	output logic signed [FRAC_BITS+2:0] angle
);
	import atan2_pkg::*;

	localparam int OUT_W  = FRAC_BITS + 3;
	localparam int OUT_W1 = OUT_W + 1;

	localparam logic [63:0] PI_R  =
		(PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
	localparam logic [63:0] HPI_R =
		(HALF_PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
	localparam logic signed [OUT_W1-1:0] PI_V  = OUT_W1'(PI_R);
	localparam logic signed [OUT_W1-1:0] HPI_V = OUT_W1'(HPI_R);

	logic en;
	assign en          = !(angle_valid && angle_stall);
	assign coord_stall = !en;

	// magnitudes at full width; the most negative input maps to 2^(W-1)
	logic [IN_WIDTH-1:0] ay, ax, mn, mx;
	atan2_side_t         side_in;

	assign ay = y_coord[IN_WIDTH-1] ? (~y_coord + 1'b1) : y_coord;
	assign ax = x_coord[IN_WIDTH-1] ? (~x_coord + 1'b1) : x_coord;

	always_comb begin
		side_in.sx   = x_coord[IN_WIDTH-1];
		side_in.sy   = y_coord[IN_WIDTH-1];
		side_in.xz   = (x_coord == '0);
		side_in.yz   = (y_coord == '0);
		side_in.swap = (ay >= ax);
		mn = side_in.swap ? ax : ay;
		mx = side_in.swap ? ay : ax;
	end

	logic              div_vld;
	logic [T_W-1:0]    div_ratio;
	atan2_side_t       div_side;

	atan2_div #(.IN_WIDTH(IN_WIDTH)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (coord_valid),
		.min_mag (mn),
		.max_mag (mx),
		.in_side (side_in),
		.out_vld (div_vld),
		.ratio   (div_ratio),
		.out_side(div_side)
	);

	logic              poly_vld;
	logic [FRAC_BITS:0] poly_mag;
	atan2_side_t       poly_side;

	atan2_poly #(.FRAC_BITS(FRAC_BITS)) u_poly (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (div_vld),
		.ratio   (div_ratio),
		.in_side (div_side),
		.out_vld (poly_vld),
		.mag     (poly_mag),
		.out_side(poly_side)
	);

	// quadrant fold
	logic signed [OUT_W1-1:0] a_x, res;
	assign a_x = $signed({3'b000, poly_mag});

	always_comb begin
		if (poly_side.xz) begin
			if (poly_side.yz)
				res = '0;
			else
				res = poly_side.sy ? -HPI_V : HPI_V;
		end else if (!poly_side.swap) begin
			if (!poly_side.sx)
				res = poly_side.sy ? -a_x : a_x;
			else
				res = poly_side.sy ? (a_x - PI_V) : (PI_V - a_x);
		end else begin
			if (!poly_side.sy)
				res = poly_side.sx ? (HPI_V + a_x) : (HPI_V - a_x);
			else
				res = poly_side.sx ? (HPI_V - a_x - PI_V) : (HPI_V + a_x - PI_V);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_valid <= 1'b0;
		end else if (en) begin
			angle_valid <= poly_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle <= res[OUT_W-1:0];
		end
	end

endmodule

`default_nettype wire
